@@ hdl/crosspoint_serial_route_loader_assert.svh @@
// Assertion macros for the crosspoint serial route loader checks.
// Used by csrl_checker; needs nothing else.
`ifndef CROSSPOINT_SERIAL_ROUTE_LOADER_ASSERT_SVH
`define CROSSPOINT_SERIAL_ROUTE_LOADER_ASSERT_SVH

// Check prop in the same cycle as cond.
`define CSRL_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("csrl check failed");

// Check prop in the cycle after cond.
`define CSRL_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("csrl check failed");

`endif

@@ hdl/csrl_pkg.sv @@
// Shared types and constants of the crosspoint serial route loader.
// No dependencies.
`default_nettype none

package csrl_pkg;

    localparam int CHIP_PORTS = 16;
    localparam int LANE_W     = 4;
    localparam int SRC_W      = 7;
    localparam int BOARD_W    = 3;
    localparam int CNT_W      = 8;
    localparam int RESULT_CAP = 16;
    localparam int WCNT_W     = 4;
    localparam int CODES_W    = CHIP_PORTS * LANE_W;
    localparam int ROW_DATA_W = CHIP_PORTS * SRC_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0]  CFG_INPUT_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0]  CFG_OUTPUT_COUNT = 1'b1;
    localparam logic [CFG_DATA_W-1:0] COUNT_RESET      = 7'd64;

    typedef enum logic [1:0] {
        FILL_OFF,
        FILL_ON,
        FILL_TABLE
    } fill_t;

    typedef struct packed {
        logic [SRC_W-1:0] source_input;
        logic [SRC_W-1:0] target_output;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         board_address;
        logic [1:0]         chip_position;
        logic [15:0]        enable_bits;
        logic [CODES_W-1:0] input_codes;
        logic               frame_end;
        logic               last;
    } word_t;

    typedef struct packed {
        fill_t                 fill;
        logic                  new_on;
        logic [BOARD_W-1:0]    board;
        logic [SRC_W-1:0]      new_src;
        logic [CHIP_PORTS-1:0] target_hit;
    } word_ctl_t;

endpackage

`default_nettype wire

@@ hdl/csrl_ram.sv @@
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module csrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hdl/csrl_word.sv @@
// Builds the enable bits and input codes of one chip reload word from a table row.
// Depends on csrl_pkg.
`default_nettype none

module csrl_word
    import csrl_pkg::*;
(
    input  word_ctl_t             ctl,
    input  logic [ROW_DATA_W-1:0] row_data,
    input  logic                  row_written,
    input  logic [CHIP_PORTS-1:0] route_valid,
    output logic [CHIP_PORTS-1:0] enable_bits,
    output logic [CODES_W-1:0]    input_codes
);

    always_comb
    begin
        logic [SRC_W-1:0]  src;
        logic              on;
        logic [LANE_W-1:0] code;
        enable_bits = '0;
        input_codes = '0;
        src         = '0;
        on          = 1'b0;
        code        = '0;
        for (int j = 0; j < CHIP_PORTS; j++)
        begin
            src  = row_written ? row_data[j*SRC_W +: SRC_W] : '0;
            on   = 1'b0;
            code = src[LANE_W-1:0];
            unique case (ctl.fill)
                FILL_OFF:
                begin
                    on = 1'b0;
                end
                FILL_ON:
                begin
                    on   = 1'b1;
                    code = ctl.new_src[LANE_W-1:0];
                end
                FILL_TABLE:
                begin
                    on = route_valid[j] && (src[SRC_W-1:LANE_W] == ctl.board);
                    if (ctl.target_hit[j])
                    begin
                        on = ctl.new_on;
                        if (ctl.new_on)
                        begin
                            code = ctl.new_src[LANE_W-1:0];
                        end
                    end
                end
                default:
                begin
                    on = 1'b0;
                end
            endcase
            enable_bits[j]                   = on;
            input_codes[j*LANE_W +: LANE_W] = code;
        end
    end

endmodule

`default_nettype wire

@@ hdl/crosspoint_serial_route_loader.sv @@
// Top level of the crosspoint serial route loader: sequencer, route table and output register.
// Depends on csrl_pkg, csrl_ram and csrl_word.
//
// Takes one route command at a time and answers with the reload words for the
// daisy-chained 16-port crosspoint chips of every board the route leaves or enters,
// highest chip first, at most sixteen words per command. The route table holds one
// row of sixteen source numbers per chip in a single-port RAM; per-output route
// valid bits and per-row written bits sit in flip-flops and are cleared by reset,
// so there is no clearing pass. Each word takes a row read, then a build and load
// into the output register, which waits while the output is stalled. A single-output
// command adds a lookup step, and every command ends with a read-modify-write of the
// table rows it changes, each row read and then written back: one row for a single
// output, one row per chip for every output. A command with a source or target out
// of range is taken and gives no words.
`default_nettype none

module crosspoint_serial_route_loader
    import csrl_pkg::*;
#(
    parameter int MAX_INPUTS  = 64,
    parameter int MAX_OUTPUTS = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  cmd_t                  cmd_data,
    output logic                  word_valid,
    input  logic                  word_stall,
    output word_t                 word_data,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ROWS  = (MAX_OUTPUTS + CHIP_PORTS - 1) / CHIP_PORTS;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IDX_W = ROW_W + LANE_W;
    localparam logic [CNT_W-1:0] ICNT_MAX = CNT_W'(MAX_INPUTS);
    localparam logic [CNT_W-1:0] OCNT_MAX = CNT_W'(MAX_OUTPUTS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_RD,
        S_EMIT,
        S_UPD_RD,
        S_UPD_WR
    } state_t;

    typedef enum logic [1:0] {
        PH_OFF,
        PH_ON,
        PH_LEAVE,
        PH_JOIN
    } phase_t;

    state_t                            state_reg, state_next;
    phase_t                            phase_reg, phase_next;
    logic [CFG_DATA_W-1:0]             input_count_reg, input_count_next;
    logic [CFG_DATA_W-1:0]             output_count_reg, output_count_next;
    logic [SRC_W-1:0]                  src_reg, src_next;
    logic [SRC_W-1:0]                  new_src_reg, new_src_next;
    logic [BOARD_W-1:0]                nb_reg, nb_next;
    logic [IDX_W-1:0]                  tgt_m1_reg, tgt_m1_next;
    logic                              all_reg, all_next;
    logic [ROW_W-1:0]                  chips_m1_reg, chips_m1_next;
    logic [BOARD_W-1:0]                boards_m1_reg, boards_m1_next;
    logic [CNT_W-1:0]                  ocnt_reg, ocnt_next;
    logic [BOARD_W-1:0]                board_reg, board_next;
    logic [ROW_W-1:0]                  chip_reg, chip_next;
    logic [WCNT_W-1:0]                 wcnt_reg, wcnt_next;
    logic [ROW_W-1:0]                  row_reg, row_next;
    logic [ROWS-1:0][CHIP_PORTS-1:0]   rv_reg, rv_next;
    logic [ROWS-1:0]                   written_reg, written_next;
    logic                              word_valid_reg, word_valid_next;
    word_t                             word_data_reg, word_data_next;

    logic [CNT_W-1:0]      icnt, ocnt, icnt_m1, ocnt_m1;
    logic [BOARD_W-1:0]    cmd_boards_m1;
    logic [ROW_W-1:0]      cmd_chips_m1;
    logic [SRC_W-1:0]      cmd_src_m1;
    logic [IDX_W-1:0]      cmd_tgt_m1;
    logic                  cmd_take, cmd_in_range, cmd_connect;
    logic [BOARD_W:0]      first_pick, next_pick;
    logic                  connect;
    logic                  nx_exists;
    phase_t                nx_phase;
    logic [BOARD_W-1:0]    nx_board;
    logic [ROW_W-1:0]      tgt_row;
    logic [LANE_W-1:0]     tgt_lane;
    logic [SRC_W-1:0]      old_src;
    logic                  old_valid, leave;
    logic                  last_word, out_load;
    logic [ROW_W+1:0]      chip_ext;
    logic                  ram_en, ram_we;
    logic [ROW_W-1:0]      ram_addr;
    logic [ROW_DATA_W-1:0] ram_wdata, ram_rdata;
    logic [CHIP_PORTS-1:0] upd_mask;
    word_ctl_t             wctl;
    logic [CHIP_PORTS-1:0] w_enable;
    logic [CODES_W-1:0]    w_codes;

    function automatic logic [BOARD_W:0] pick_off(
        input logic [BOARD_W:0]   start,
        input logic               conn,
        input logic [BOARD_W-1:0] skip,
        input logic [BOARD_W-1:0] top
    );
        logic [BOARD_W:0] c;
        c = start;
        if (conn && (c == {1'b0, skip}))
        begin
            c = c + 1'b1;
        end
        return {(c <= {1'b0, top}), c[BOARD_W-1:0]};
    endfunction

    csrl_ram #(
        .WIDTH (ROW_DATA_W),
        .DEPTH (ROWS)
    ) u_table (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    csrl_word u_word (
        .ctl         (wctl),
        .row_data    (ram_rdata),
        .row_written (written_reg[chip_reg]),
        .route_valid (rv_reg[chip_reg]),
        .enable_bits (w_enable),
        .input_codes (w_codes)
    );

    // Clamp the fitted counts and derive board and chip counts.
    always_comb
    begin
        if (input_count_reg == '0)
        begin
            icnt = CNT_W'(1);
        end
        else if ({1'b0, input_count_reg} > ICNT_MAX)
        begin
            icnt = ICNT_MAX;
        end
        else
        begin
            icnt = {1'b0, input_count_reg};
        end
        if (output_count_reg == '0)
        begin
            ocnt = CNT_W'(1);
        end
        else if ({1'b0, output_count_reg} > OCNT_MAX)
        begin
            ocnt = OCNT_MAX;
        end
        else
        begin
            ocnt = {1'b0, output_count_reg};
        end
    end

    assign icnt_m1       = icnt - 1'b1;
    assign ocnt_m1       = ocnt - 1'b1;
    assign cmd_boards_m1 = icnt_m1[LANE_W +: BOARD_W];
    assign cmd_chips_m1  = ROW_W'(ocnt_m1 >> LANE_W);

    assign cmd_stall    = (state_reg != S_IDLE);
    assign cmd_take     = cmd_valid && !cmd_stall;
    assign cmd_in_range = ({1'b0, cmd_data.source_input} <= icnt)
                       && ({1'b0, cmd_data.target_output} <= ocnt);
    assign cmd_connect  = (cmd_data.source_input != '0);
    assign cmd_src_m1   = cmd_data.source_input - 1'b1;
    assign cmd_tgt_m1   = IDX_W'(cmd_data.target_output - 1'b1);
    assign first_pick   = pick_off('0, cmd_connect, cmd_src_m1[SRC_W-1:LANE_W], cmd_boards_m1);

    assign connect   = (src_reg != '0);
    assign tgt_row   = tgt_m1_reg[IDX_W-1:LANE_W];
    assign tgt_lane  = tgt_m1_reg[LANE_W-1:0];
    assign old_src   = written_reg[tgt_row] ? ram_rdata[tgt_lane*SRC_W +: SRC_W] : '0;
    assign old_valid = rv_reg[tgt_row][tgt_lane];
    assign leave     = !connect || (old_valid && (old_src[SRC_W-1:LANE_W] != nb_reg));
    assign next_pick = pick_off({1'b0, board_reg} + 1'b1, connect, nb_reg, boards_m1_reg);

    // Pick the board load that follows the current one.
    always_comb
    begin
        nx_exists = 1'b0;
        nx_phase  = phase_reg;
        nx_board  = board_reg;
        unique case (phase_reg)
            PH_OFF:
            begin
                if (next_pick[BOARD_W])
                begin
                    nx_exists = 1'b1;
                    nx_board  = next_pick[BOARD_W-1:0];
                end
                else if (connect)
                begin
                    nx_exists = 1'b1;
                    nx_phase  = PH_ON;
                    nx_board  = nb_reg;
                end
            end
            PH_LEAVE:
            begin
                if (connect)
                begin
                    nx_exists = 1'b1;
                    nx_phase  = PH_JOIN;
                    nx_board  = nb_reg;
                end
            end
            PH_ON, PH_JOIN:
            begin
                nx_exists = 1'b0;
            end
            default:
            begin
                nx_exists = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        unique case (phase_reg)
            PH_OFF:   wctl.fill = FILL_OFF;
            PH_ON:    wctl.fill = FILL_ON;
            default:  wctl.fill = FILL_TABLE;
        endcase
        wctl.new_on     = (phase_reg == PH_JOIN);
        wctl.board      = board_reg;
        wctl.new_src    = new_src_reg;
        wctl.target_hit = (!all_reg && (tgt_row == chip_reg))
                        ? (CHIP_PORTS'(1) << tgt_lane) : '0;
    end

    assign last_word = (wcnt_reg == WCNT_W'(RESULT_CAP - 1)) || ((chip_reg == '0) && !nx_exists);
    assign chip_ext  = {2'b00, chip_reg};

    always_comb
    begin
        word_data_next.board_address = board_reg[1:0];
        word_data_next.chip_position = chip_ext[1:0];
        word_data_next.enable_bits   = w_enable;
        word_data_next.input_codes   = w_codes;
        word_data_next.frame_end     = (chip_reg == '0);
        word_data_next.last          = last_word;
    end

    // Merge the new route into the row being rewritten.
    always_comb
    begin
        logic [IDX_W-1:0] idx;
        logic [SRC_W-1:0] old;
        idx       = '0;
        old       = '0;
        upd_mask  = '0;
        ram_wdata = '0;
        for (int j = 0; j < CHIP_PORTS; j++)
        begin
            idx = {row_reg, LANE_W'(j)};
            old = written_reg[row_reg] ? ram_rdata[j*SRC_W +: SRC_W] : '0;
            upd_mask[j] = all_reg ? (CNT_W'(idx) < ocnt_reg) : (idx == tgt_m1_reg);
            ram_wdata[j*SRC_W +: SRC_W] = (upd_mask[j] && connect) ? new_src_reg : old;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        input_count_next  = input_count_reg;
        output_count_next = output_count_reg;
        src_next          = src_reg;
        new_src_next      = new_src_reg;
        nb_next           = nb_reg;
        tgt_m1_next       = tgt_m1_reg;
        all_next          = all_reg;
        chips_m1_next     = chips_m1_reg;
        boards_m1_next    = boards_m1_reg;
        ocnt_next         = ocnt_reg;
        board_next        = board_reg;
        chip_next         = chip_reg;
        wcnt_next         = wcnt_reg;
        row_next          = row_reg;
        rv_next           = rv_reg;
        written_next      = written_reg;
        word_valid_next   = word_valid_reg;
        out_load          = 1'b0;
        ram_en            = 1'b0;
        ram_we            = 1'b0;
        ram_addr          = chip_reg;

        if (word_valid_reg && !word_stall)
        begin
            word_valid_next = 1'b0;
        end

        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_INPUT_COUNT:  input_count_next  = cfg_data;
                CFG_OUTPUT_COUNT: output_count_next = cfg_data;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_take && cmd_in_range)
                begin
                    src_next       = cmd_data.source_input;
                    new_src_next   = cmd_src_m1;
                    nb_next        = cmd_src_m1[SRC_W-1:LANE_W];
                    tgt_m1_next    = cmd_tgt_m1;
                    all_next       = (cmd_data.target_output == '0);
                    chips_m1_next  = cmd_chips_m1;
                    boards_m1_next = cmd_boards_m1;
                    ocnt_next      = ocnt;
                    chip_next      = cmd_chips_m1;
                    wcnt_next      = '0;
                    if (cmd_data.target_output == '0)
                    begin
                        if (first_pick[BOARD_W])
                        begin
                            phase_next = PH_OFF;
                            board_next = first_pick[BOARD_W-1:0];
                        end
                        else
                        begin
                            phase_next = PH_ON;
                            board_next = cmd_src_m1[SRC_W-1:LANE_W];
                        end
                        state_next = S_RD;
                    end
                    else
                    begin
                        ram_en     = 1'b1;
                        ram_addr   = cmd_tgt_m1[IDX_W-1:LANE_W];
                        state_next = S_LOOK;
                    end
                end
            end
            S_LOOK:
            begin
                if (leave)
                begin
                    phase_next = PH_LEAVE;
                    board_next = old_src[SRC_W-1:LANE_W];
                end
                else
                begin
                    phase_next = PH_JOIN;
                    board_next = nb_reg;
                end
                state_next = S_RD;
            end
            S_RD:
            begin
                ram_en     = 1'b1;
                ram_addr   = chip_reg;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!word_valid_reg || !word_stall)
                begin
                    out_load        = 1'b1;
                    word_valid_next = 1'b1;
                    wcnt_next       = wcnt_reg + 1'b1;
                    if (last_word)
                    begin
                        row_next   = all_reg ? '0 : tgt_row;
                        state_next = S_UPD_RD;
                    end
                    else if (chip_reg != '0)
                    begin
                        chip_next  = chip_reg - 1'b1;
                        state_next = S_RD;
                    end
                    else
                    begin
                        phase_next = nx_phase;
                        board_next = nx_board;
                        chip_next  = chips_m1_reg;
                        state_next = S_RD;
                    end
                end
            end
            S_UPD_RD:
            begin
                ram_en     = 1'b1;
                ram_addr   = row_reg;
                state_next = S_UPD_WR;
            end
            S_UPD_WR:
            begin
                ram_en                = 1'b1;
                ram_we                = 1'b1;
                ram_addr              = row_reg;
                written_next[row_reg] = 1'b1;
                for (int j = 0; j < CHIP_PORTS; j++)
                begin
                    if (upd_mask[j])
                    begin
                        rv_next[row_reg][j] = connect;
                    end
                end
                if (all_reg && (row_reg != chips_m1_reg))
                begin
                    row_next   = row_reg + 1'b1;
                    state_next = S_UPD_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            phase_reg        <= PH_OFF;
            input_count_reg  <= COUNT_RESET;
            output_count_reg <= COUNT_RESET;
            src_reg          <= '0;
            new_src_reg      <= '0;
            nb_reg           <= '0;
            tgt_m1_reg       <= '0;
            all_reg          <= 1'b0;
            chips_m1_reg     <= '0;
            boards_m1_reg    <= '0;
            ocnt_reg         <= '0;
            board_reg        <= '0;
            chip_reg         <= '0;
            wcnt_reg         <= '0;
            row_reg          <= '0;
            rv_reg           <= '0;
            written_reg      <= '0;
            word_valid_reg   <= 1'b0;
            word_data_reg    <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            input_count_reg  <= input_count_next;
            output_count_reg <= output_count_next;
            src_reg          <= src_next;
            new_src_reg      <= new_src_next;
            nb_reg           <= nb_next;
            tgt_m1_reg       <= tgt_m1_next;
            all_reg          <= all_next;
            chips_m1_reg     <= chips_m1_next;
            boards_m1_reg    <= boards_m1_next;
            ocnt_reg         <= ocnt_next;
            board_reg        <= board_next;
            chip_reg         <= chip_next;
            wcnt_reg         <= wcnt_next;
            row_reg          <= row_next;
            rv_reg           <= rv_next;
            written_reg      <= written_next;
            word_valid_reg   <= word_valid_next;
            // Hold the word until the transaction completes.
            if (out_load)
            begin
                word_data_reg <= word_data_next;
            end
        end
    end

    assign word_valid = word_valid_reg;
    assign word_data  = word_data_reg;

endmodule

`default_nettype wire

@@ hdl/csrl_checker.sv @@
// Port-level checks of the crosspoint serial route loader, bound to the top level.
// Depends on csrl_pkg and crosspoint_serial_route_loader_assert.svh.
`default_nettype none

`include "crosspoint_serial_route_loader_assert.svh"

module csrl_checker
    import csrl_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  cmd_valid,
    input logic  cmd_stall,
    input cmd_t  cmd_data,
    input logic  word_valid,
    input logic  word_stall,
    input word_t word_data
);

    `CSRL_ASSERT_NEXT(a_word_hold, clk, rst_n, word_valid && word_stall, word_valid && $stable(word_data))
    `CSRL_ASSERT_NEXT(a_cmd_hold, clk, rst_n, cmd_valid && cmd_stall, cmd_valid && $stable(cmd_data))
    `CSRL_ASSERT_NOW(a_frame_chip0, clk, rst_n, word_valid && word_data.frame_end, word_data.chip_position == 2'd0)
    `CSRL_ASSERT_NOW(a_busy_mid_cmd, clk, rst_n, word_valid && !word_data.last, cmd_stall)

endmodule

bind crosspoint_serial_route_loader csrl_checker u_csrl_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd_data   (cmd_data),
    .word_valid (word_valid),
    .word_stall (word_stall),
    .word_data  (word_data)
);

`default_nettype wire
